// ----- rtl/cclp_pkg.sv -----
// cclp_pkg: shared codes, limits and string tables of the command line parser
// used by the parser top level, its checker and the testbench
package cclp_pkg;

  localparam int RESP_DEPTH = 32;
  localparam int PADDR_W    = 3;

  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BOOT  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  localparam logic [31:0] RATE_MIN = 32'd5000;
  localparam logic [31:0] RATE_MAX = 32'd120000016;
  localparam logic [31:0] ADC_PIN_OFS = 32'd26;
  localparam logic [31:0] PIN_SKIP_LIMIT = 32'd22;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] CMD_BOOT  = 8'h62; // b
  localparam logic [7:0] CMD_ID    = 8'h69; // i
  localparam logic [7:0] CMD_RATE  = 8'h52; // R
  localparam logic [7:0] CMD_LEN   = 8'h4C; // L
  localparam logic [7:0] CMD_ANA   = 8'h61; // a
  localparam logic [7:0] CMD_FIXED = 8'h46; // F
  localparam logic [7:0] CMD_CONT  = 8'h43; // C
  localparam logic [7:0] CMD_T     = 8'h74; // t
  localparam logic [7:0] CMD_P     = 8'h70; // p
  localparam logic [7:0] CMD_AEN   = 8'h41; // A
  localparam logic [7:0] CMD_DEN   = 8'h44; // D
  localparam logic [7:0] CMD_NAME  = 8'h6E; // n

  localparam logic [PADDR_W-1:0] ADDR_PIN_MAP = '0;

  typedef enum logic [2:0] {
    STR_STAR, STR_ID, STR_1D, STR_C02, STR_GP, STR_ADC, STR_UGP, STR_ANA
  } str_e;

  function automatic logic [3:0] str_len(str_e s);
    logic [3:0] n;
    case (s)
      STR_STAR: n = 4'd1;
      STR_ID:   n = 4'd8;
      STR_1D:   n = 4'd2;
      STR_C02:  n = 4'd3;
      STR_GP:   n = 4'd2;
      STR_ADC:  n = 4'd3;
      STR_UGP:  n = 4'd3;
      STR_ANA:  n = 4'd7;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] str_byte(str_e s, logic [2:0] k);
    logic [63:0] w;
    case (s)
      STR_STAR: w = {8'h2A, 56'h0};
      STR_ID:   w = 64'h5352_5049_434F_2C41;
      STR_1D:   w = {16'h3144, 48'h0};
      STR_C02:  w = {24'h2C30_32, 40'h0};
      STR_GP:   w = {16'h4750, 48'h0};
      STR_ADC:  w = {24'h4144_43, 40'h0};
      STR_UGP:  w = {24'h5F47_50, 40'h0};
      STR_ANA:  w = {56'h3235_3730_3078_30, 8'h0};
      default:  w = '0;
    endcase
    return w[63 - 8 * k -: 8];
  endfunction

  function automatic logic [7:0] boot_char(logic [2:0] k);
    logic [63:0] w;
    w = 64'h626F_6F74_7365_6C00;
    return w[63 - 8 * k -: 8];
  endfunction

endpackage

// ----- rtl/cclp_if.sv -----
// cclp_char_if: command character request channel
// cclp_res_if: result request channel; no package dependency
interface cclp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, char_in, input ready);
  modport sink (input valid, char_in, output ready);
endinterface

interface cclp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  resp_byte;
  logic        resp_last;
  logic        continuous;
  logic [26:0] rate_hz;
  logic [30:0] sample_total;
  logic [31:0] analog_mask;
  logic [31:0] digital_mask;
  logic [5:0]  analog_count;
  logic [5:0]  digital_count;
  logic [3:0]  nibbles_per_slice;
  logic [2:0]  digital_bytes_per_sample;
  modport source (output valid, kind, resp_byte, resp_last, continuous, rate_hz,
                  sample_total, analog_mask, digital_mask, analog_count, digital_count,
                  nibbles_per_slice, digital_bytes_per_sample, input ready);
  modport sink (input valid, kind, resp_byte, resp_last, continuous, rate_hz,
                sample_total, analog_mask, digital_mask, analog_count, digital_count,
                nibbles_per_slice, digital_bytes_per_sample, output ready);
endinterface

// ----- rtl/cclp_bcd.sv -----
// cclp_bcd: shift-and-add-3 binary to decimal converter, one bit per cycle
// standalone; used by the parser top level for decimal responses
module cclp_bcd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] bin_i,
  output logic        done_o,
  output logic [39:0] bcd_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] sh_q;
  logic [39:0] bcd_q, adj;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bcd_q <= {adj[38:0], sh_q[31]};
      sh_q  <= {sh_q[30:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ----- rtl/capture_command_line_parser.sv -----
// capture_command_line_parser: command characters in, response and control requests out
// depends on cclp_pkg, cclp_if (channel interfaces) and cclp_bcd
//
// cmd_i takes one command character per request; res_o gives result requests.
// the APB port holds pin_map_mode at byte address 0; pready is always high.
// an ordinary character is stored and the block stays ready.
// '*' gives one abort request on the next cycle.
// CR or LF runs the line through a sequencer: dispatch, parsing of each
// character, building of each response byte, each decimal number in the shared
// binary-to-decimal unit and then its digits, the channel count walk of a
// capture start, then sending of each response byte as res_o takes it.
// cmd_i.ready is low while a line executes or a result waits; a stalled
// result holds in its output register until res_o.ready.
// reset: empty line, rate 5000, count 10, masks and counts zero, pin map 0.
// the line buffer comes up unwritten; unwritten positions are never read.
module capture_command_line_parser #(
  parameter int ANALOG_CHANNELS  = 3,
  parameter int DIGITAL_CHANNELS = 21,
  parameter int LINE_DEPTH       = 19
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cclp_char_if.sink                     cmd_i,
  cclp_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cclp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cclp_pkg::*;

  localparam int LW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int IW = $clog2(LINE_DEPTH + 1);
  localparam int RW = $clog2(RESP_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_C0, S_C1, S_DISP, S_BOOT, S_PARSE, S_ACT, S_CNT, S_OP, S_STR,
    S_DEC_INIT, S_DEC_WAIT, S_DIGS, S_RD, S_LOAD, S_WAIT, S_DONE
  } state_e;

  typedef enum logic [2:0] {P_STAR, P_ID, P_ANA, P_ND, P_NA} prog_e;
  typedef enum logic [1:0] {OP_STR, OP_DEC, OP_SEND} op_e;

  state_e      state_q;
  logic [IW-1:0] len_q, idx_q;
  logic [7:0]  c0_q, c1_q;
  logic        exec_q;
  logic [26:0] rate_q;
  logic [30:0] count_q;
  logic [31:0] amask_q, dmask_q;
  logic        cont_q;
  logic [5:0]  acnt_q, dcnt_q, ta_q, td_q;
  logic [3:0]  nps_q;
  logic [2:0]  dbps_q;
  logic [1:0]  mode_q;
  logic [31:0] mag_q, num_q, dval_q;
  logic        neg_q, phase_q;
  prog_e       prog_q;
  logic [2:0]  step_q, sk_q;
  str_e        str_q;
  logic [3:0]  mind_q, didx_q;
  logic        started_q;
  logic [RW:0] rlen_q;
  logic [RW-1:0] sidx_q;
  logic [7:0]  rdata_q;
  logic        out_valid_q, last_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [4:0]  ci_q;

  logic [7:0]  lbuf [LINE_DEPTH];
  logic [7:0]  rmem [RESP_DEPTH];

  logic        cmd_acc, lb_we;
  logic [LW-1:0] lb_waddr;
  logic [7:0]  cur_ch;
  logic        is_ws, is_digit;
  logic [35:0] mag10;
  logic [31:0] parsed, pin;
  logic        resp_we;
  logic [7:0]  resp_wd;
  logic [3:0]  dig;
  logic        bcd_start, bcd_done;
  logic [31:0] bcd_bin;
  logic [39:0] bcd;
  op_e         op_kind;
  str_e        op_str;
  logic [31:0] op_val;
  logic [3:0]  op_mind;
  logic [5:0]  ta_n, td_n;
  logic [3:0]  nps_n;
  logic [2:0]  dbps_n;

  cclp_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (bcd_bin),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign lb_we       = cmd_acc && (cmd_i.char_in != CH_STAR) && (cmd_i.char_in != CH_CR)
                       && (cmd_i.char_in != CH_LF);
  assign lb_waddr    = (len_q >= IW'(LINE_DEPTH)) ? '0 : len_q[LW-1:0];

  assign cur_ch   = (idx_q < len_q) ? lbuf[idx_q[LW-1:0]] : 8'h00;
  assign is_ws    = (cur_ch == CH_SPACE) || ((cur_ch >= 8'd9) && (cur_ch <= 8'd13));
  assign is_digit = (cur_ch >= CH_ZERO) && (cur_ch <= CH_NINE);
  assign mag10    = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {28'h0, cur_ch - CH_ZERO};
  assign parsed   = neg_q ? (32'h0 - mag_q) : (mag_q[31] ? 32'h7FFF_FFFF : mag_q);

  always_comb begin
    pin = num_q;
    case (mode_q)
      2'd0: pin = num_q + 32'd2;
      2'd1: if (!num_q[31] && (num_q > PIN_SKIP_LIMIT)) pin = num_q + 32'd3;
      default: pin = num_q;
    endcase
  end

  // response program: which string or number comes next
  always_comb begin
    op_kind = OP_SEND;
    op_str  = STR_STAR;
    op_val  = '0;
    op_mind = 4'd1;
    case (prog_q)
      P_STAR: if (step_q == 3'd0) op_kind = OP_STR;
      P_ANA: if (step_q == 3'd0) begin
        op_kind = OP_STR;
        op_str  = STR_ANA;
      end
      P_ID: begin
        case (step_q)
          3'd0: begin op_kind = OP_STR; op_str = STR_ID; end
          3'd1: begin op_kind = OP_DEC; op_val = 32'(ANALOG_CHANNELS); op_mind = 4'd2; end
          3'd2: begin op_kind = OP_STR; op_str = STR_1D; end
          3'd3: begin op_kind = OP_DEC; op_val = 32'(DIGITAL_CHANNELS); op_mind = 4'd2; end
          3'd4: begin op_kind = OP_STR; op_str = STR_C02; end
          default: op_kind = OP_SEND;
        endcase
      end
      P_ND: begin
        case (step_q)
          3'd0: begin op_kind = OP_STR; op_str = STR_GP; end
          3'd1: begin op_kind = OP_DEC; op_val = pin; end
          default: op_kind = OP_SEND;
        endcase
      end
      P_NA: begin
        case (step_q)
          3'd0: begin op_kind = OP_STR; op_str = STR_ADC; end
          3'd1: begin op_kind = OP_DEC; op_val = num_q; end
          3'd2: begin op_kind = OP_STR; op_str = STR_UGP; end
          3'd3: begin op_kind = OP_DEC; op_val = num_q + ADC_PIN_OFS; end
          default: op_kind = OP_SEND;
        endcase
      end
      default: op_kind = OP_SEND;
    endcase
  end

  assign dig       = bcd[4*didx_q +: 4];
  assign bcd_start = (state_q == S_DEC_INIT);
  assign bcd_bin   = dval_q[31] ? (32'h0 - dval_q) : dval_q;

  always_comb begin
    resp_we = 1'b0;
    resp_wd = 8'h00;
    case (state_q)
      S_STR: begin
        resp_we = 1'b1;
        resp_wd = str_byte(str_q, sk_q);
      end
      S_DEC_INIT: begin
        resp_we = dval_q[31];
        resp_wd = CH_MINUS;
      end
      S_DIGS: begin
        resp_we = (dig != 4'd0) || started_q || (didx_q < mind_q);
        resp_wd = CH_ZERO + {4'h0, dig};
      end
      default: resp_we = 1'b0;
    endcase
    if (rlen_q[RW]) resp_we = 1'b0;
  end

  // channel count walk results
  always_comb begin
    ta_n = ta_q;
    td_n = td_q;
    if (({1'b0, ci_q} < 6'(ANALOG_CHANNELS)) && amask_q[ci_q]) ta_n = ta_q + 6'd1;
    if (({1'b0, ci_q} < 6'(DIGITAL_CHANNELS)) && dmask_q[ci_q]) td_n = td_q + 6'd1;
    nps_n = {3'b000, |dmask_q[3:0]} + {3'b000, |dmask_q[7:4]} + {2'b00, |dmask_q[15:8], 1'b0}
            + {1'b0, |dmask_q[31:16], 2'b00};
    if ((nps_n == 4'd1) && (ta_n != 6'd0)) nps_n = 4'd2;
    if (td_n == 6'd0)       dbps_n = 3'd0;
    else if (td_n <= 6'd7)  dbps_n = 3'd1;
    else if (td_n <= 6'd14) dbps_n = 3'd2;
    else if (td_n <= 6'd21) dbps_n = 3'd3;
    else if (td_n <= 6'd28) dbps_n = 3'd4;
    else                    dbps_n = 3'd5;
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) lbuf[lb_waddr] <= cmd_i.char_in;
  end

  always_ff @(posedge clk_i) begin
    if (resp_we) rmem[rlen_q[RW-1:0]] <= resp_wd;
    rdata_q <= rmem[sidx_q];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_PIN_MAP[2])) begin
      mode_q <= pwdata[1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_PIN_MAP[2]) ? {30'h0, mode_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      exec_q      <= 1'b0;
      rate_q      <= 27'(RATE_MIN);
      count_q     <= 31'd10;
      amask_q     <= '0;
      dmask_q     <= '0;
      cont_q      <= 1'b0;
      acnt_q      <= '0;
      dcnt_q      <= '0;
      nps_q       <= '0;
      dbps_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      kind_q      <= KIND_RESP;
      byte_q      <= '0;
      rlen_q      <= '0;
      sidx_q      <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      mag_q       <= '0;
      num_q       <= '0;
      dval_q      <= '0;
      neg_q       <= 1'b0;
      phase_q     <= 1'b0;
      prog_q      <= P_STAR;
      step_q      <= '0;
      sk_q        <= '0;
      str_q       <= STR_STAR;
      mind_q      <= '0;
      didx_q      <= '0;
      started_q   <= 1'b0;
      ci_q        <= '0;
      ta_q        <= '0;
      td_q        <= '0;
    end else begin
      if (resp_we) rlen_q <= rlen_q + 1'b1;
      case (state_q)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd_i.char_in == CH_STAR) begin
              cont_q      <= 1'b0;
              exec_q      <= 1'b0;
              kind_q      <= KIND_ABORT;
              byte_q      <= 8'h00;
              last_q      <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= S_WAIT;
            end else if ((cmd_i.char_in == CH_CR) || (cmd_i.char_in == CH_LF)) begin
              exec_q  <= 1'b1;
              idx_q   <= '0;
              state_q <= S_C0;
            end else begin
              len_q <= (len_q >= IW'(LINE_DEPTH)) ? IW'(1) : len_q + IW'(1);
            end
          end
        end
        S_C0: begin
          c0_q    <= cur_ch;
          idx_q   <= IW'(1);
          state_q <= S_C1;
        end
        S_C1: begin
          c1_q    <= cur_ch;
          state_q <= S_DISP;
        end
        S_DISP: begin
          rlen_q  <= '0;
          step_q  <= '0;
          mag_q   <= '0;
          neg_q   <= 1'b0;
          phase_q <= 1'b0;
          case (c0_q)
            CMD_BOOT: begin
              idx_q   <= '0;
              state_q <= S_BOOT;
            end
            CMD_ID: begin
              prog_q  <= P_ID;
              state_q <= S_OP;
            end
            CMD_RATE, CMD_LEN, CMD_ANA: begin
              idx_q   <= IW'(1);
              state_q <= S_PARSE;
            end
            CMD_AEN, CMD_DEN, CMD_NAME: begin
              idx_q   <= IW'(2);
              state_q <= S_PARSE;
            end
            CMD_FIXED, CMD_CONT: begin
              ci_q    <= '0;
              ta_q    <= '0;
              td_q    <= '0;
              state_q <= S_CNT;
            end
            CMD_T, CMD_P: begin
              prog_q  <= P_STAR;
              state_q <= S_OP;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_BOOT: begin
          if (cur_ch != boot_char(idx_q[2:0])) begin
            state_q <= S_DONE;
          end else if (idx_q == IW'(7)) begin
            exec_q      <= 1'b1;
            kind_q      <= KIND_BOOT;
            byte_q      <= 8'h00;
            last_q      <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_WAIT;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_PARSE: begin
          if (!phase_q) begin
            if (is_ws) begin
              idx_q <= idx_q + IW'(1);
            end else if ((cur_ch == CH_PLUS) || (cur_ch == CH_MINUS)) begin
              neg_q   <= (cur_ch == CH_MINUS);
              idx_q   <= idx_q + IW'(1);
              phase_q <= 1'b1;
            end else begin
              phase_q <= 1'b1;
            end
          end else if (is_digit) begin
            mag_q <= (mag10 > 36'h0_8000_0000) ? 32'h8000_0000 : mag10[31:0];
            idx_q <= idx_q + IW'(1);
          end else begin
            num_q   <= parsed;
            state_q <= S_ACT;
          end
        end
        S_ACT: begin
          state_q <= S_DONE;
          prog_q  <= P_STAR;
          case (c0_q)
            CMD_RATE: begin
              if (!num_q[31] && (num_q >= RATE_MIN) && (num_q <= RATE_MAX)) begin
                rate_q  <= num_q[26:0];
                state_q <= S_OP;
              end
            end
            CMD_LEN: begin
              if (!num_q[31] && (num_q != 32'h0)) begin
                count_q <= num_q[30:0];
                state_q <= S_OP;
              end
            end
            CMD_ANA: begin
              if (!num_q[31]) prog_q <= P_ANA;
              state_q <= S_OP;
            end
            CMD_AEN, CMD_DEN: begin
              if (((c1_q == CH_ZERO) || (c1_q == CH_ONE)) && (num_q[31:5] == 27'h0)) begin
                if (c0_q == CMD_AEN) amask_q[num_q[4:0]] <= c1_q[0];
                else                 dmask_q[num_q[4:0]] <= c1_q[0];
                state_q <= S_OP;
              end
            end
            CMD_NAME: begin
              if (c1_q == CMD_DEN) begin
                prog_q  <= P_ND;
                state_q <= S_OP;
              end else if (c1_q == CMD_AEN) begin
                prog_q  <= P_NA;
                state_q <= S_OP;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_CNT: begin
          ta_q <= ta_n;
          td_q <= td_n;
          ci_q <= ci_q + 5'd1;
          if (ci_q == 5'd31) begin
            acnt_q      <= ta_n;
            dcnt_q      <= td_n;
            nps_q       <= nps_n;
            dbps_q      <= dbps_n;
            cont_q      <= (c0_q == CMD_CONT);
            kind_q      <= KIND_START;
            byte_q      <= 8'h00;
            last_q      <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_WAIT;
          end
        end
        S_OP: begin
          step_q <= step_q + 3'd1;
          case (op_kind)
            OP_STR: begin
              str_q   <= op_str;
              sk_q    <= '0;
              state_q <= S_STR;
            end
            OP_DEC: begin
              dval_q  <= op_val;
              mind_q  <= op_mind;
              state_q <= S_DEC_INIT;
            end
            default: begin
              sidx_q  <= '0;
              state_q <= (rlen_q == '0) ? S_DONE : S_RD;
            end
          endcase
        end
        S_STR: begin
          sk_q <= sk_q + 3'd1;
          if ({1'b0, sk_q} == str_len(str_q) - 4'd1) state_q <= S_OP;
        end
        S_DEC_INIT: state_q <= S_DEC_WAIT;
        S_DEC_WAIT: begin
          if (bcd_done) begin
            didx_q    <= 4'd9;
            started_q <= 1'b0;
            state_q   <= S_DIGS;
          end
        end
        S_DIGS: begin
          if (resp_we) started_q <= 1'b1;
          if (didx_q == 4'd0) state_q <= S_OP;
          else                didx_q <= didx_q - 4'd1;
        end
        S_RD: state_q <= S_LOAD;
        S_LOAD: begin
          kind_q      <= KIND_RESP;
          byte_q      <= rdata_q;
          last_q      <= ({1'b0, sidx_q} == rlen_q - 1'b1);
          out_valid_q <= 1'b1;
          state_q     <= S_WAIT;
        end
        S_WAIT: begin
          if (res_o.ready) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= exec_q ? S_DONE : S_IDLE;
            end else begin
              sidx_q  <= sidx_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_DONE: begin
          len_q   <= '0;
          exec_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid                    = out_valid_q;
  assign res_o.kind                     = kind_q;
  assign res_o.resp_byte                = byte_q;
  assign res_o.resp_last                = last_q;
  assign res_o.continuous               = cont_q;
  assign res_o.rate_hz                  = rate_q;
  assign res_o.sample_total             = count_q;
  assign res_o.analog_mask              = amask_q;
  assign res_o.digital_mask             = dmask_q;
  assign res_o.analog_count             = acnt_q;
  assign res_o.digital_count            = dcnt_q;
  assign res_o.nibbles_per_slice        = nps_q;
  assign res_o.digital_bytes_per_sample = dbps_q;

endmodule

// ----- rtl/cclp_checker.sv -----
// cclp_checker: port-level properties of the command line parser
// depends on cclp_pkg; bound to capture_command_line_parser below
module cclp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [7:0] cmd_char,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [7:0] res_byte,
  input logic       res_last
);
  import cclp_pkg::*;

  // stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // one request at a time: no new character while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_ready && res_valid))
    else $error("ready while a result is pending");

  // abort answers at once
  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready && (cmd_char == CH_STAR)
    |=> res_valid && (res_kind == KIND_ABORT) && res_last)
    else $error("abort request missing");

  // ordinary characters are stored and ready stays high
  a_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready && (cmd_char != CH_STAR) && (cmd_char != CH_CR)
    && (cmd_char != CH_LF) |=> cmd_ready)
    else $error("character store stalled");

  // control requests are single and carry no byte
  a_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_kind != KIND_RESP) |-> res_last && (res_byte == 8'h00))
    else $error("bad control request");

endmodule

bind capture_command_line_parser cclp_checker u_cclp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .cmd_valid (cmd_i.valid),
  .cmd_ready (cmd_i.ready),
  .cmd_char  (cmd_i.char_in),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_kind  (res_o.kind),
  .res_byte  (res_o.resp_byte),
  .res_last  (res_o.resp_last)
);

// ----- test/tb_capture_command_line_parser.sv -----
`timescale 1ns / 100ps
// tb_capture_command_line_parser: random and directed command lines against an
// in-bench parser model; depends on cclp_pkg, cclp_if and the parser rtl
module tb_capture_command_line_parser;
  import cclp_pkg::*;

  localparam int LINE_MAX    = 19;
  localparam int REPLY_MAX   = 32;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_CHARS = 95;

  typedef enum int {LINE_IGNORED, LINE_REPLY, LINE_START, LINE_BOOT} line_outcome_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  resp_byte;
    logic        resp_last;
    logic        continuous;
    logic [26:0] rate_hz;
    logic [30:0] sample_total;
    logic [31:0] analog_mask;
    logic [31:0] digital_mask;
    logic [5:0]  analog_count;
    logic [5:0]  digital_count;
    logic [3:0]  nibbles_per_slice;
    logic [2:0]  digital_bytes_per_sample;
  } result_t;

  localparam logic [7:0] ID_HEAD [6] = '{8'h53, 8'h52, 8'h50, 8'h49, 8'h43, 8'h4F};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cclp_char_if cmd_ch ();
  cclp_res_if  res_ch ();

  capture_command_line_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // parser model state
  logic [7:0]  line_mem [LINE_MAX];
  int unsigned line_len;
  logic [31:0] rate_q, count_q, amask_q, dmask_q;
  logic        cont_q;
  logic [5:0]  acnt_q, dcnt_q;
  logic [3:0]  nib_q;
  logic [2:0]  dbytes_q;
  logic [1:0]  pin_mode;
  logic [7:0]  reply [$];
  result_t     step_out [$];
  result_t     expected_results [$];

  logic [7:0]  char_queue [$];
  bit          cmd_taken;
  int          send_idle, recv_stall;
  int          cycles, errors, chars_queued, chars_done, results_seen;
  int          n_reply, n_start, n_boot, n_abort;

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] line_at(int unsigned i);
    return (i < line_len && i < LINE_MAX) ? line_mem[i] : 8'h00;
  endfunction

  function automatic logic [31:0] decimal_at(int unsigned i);
    logic [63:0] mag;
    logic        neg;
    logic [7:0]  c;
    mag = 0;
    neg = 0;
    c = line_at(i);
    while (c == CH_SPACE || (c >= 8'h09 && c <= CH_CR)) begin
      i++;
      c = line_at(i);
    end
    if (c == CH_PLUS || c == CH_MINUS) begin
      neg = (c == CH_MINUS);
      i++;
      c = line_at(i);
    end
    while (c >= CH_ZERO && c <= CH_NINE) begin
      mag = mag * 10 + 64'(c - CH_ZERO);
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      i++;
      c = line_at(i);
    end
    if (neg) return 32'd0 - mag[31:0];
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic void reply_byte(logic [7:0] b);
    if (reply.size() < REPLY_MAX) reply.push_back(b);
  endfunction

  function automatic void reply_text(string s);
    for (int k = 0; k < s.len(); k++) reply_byte(s[k]);
  endfunction

  function automatic void reply_dec(logic [31:0] v, int min_digits);
    logic [7:0] d [$];
    if (v[31]) begin
      reply_byte(CH_MINUS);
      v = ~v + 1;
    end
    do begin
      d.push_back(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0 && d.size() < 10);
    while (d.size() < min_digits) d.push_back(CH_ZERO);
    while (d.size() > 0) reply_byte(d.pop_back());
  endfunction

  // returns {ok, new mask} for the A and D commands
  function automatic logic [32:0] with_bit(logic [31:0] m);
    logic [7:0]  x;
    logic [31:0] ch;
    x = line_at(1);
    ch = decimal_at(2);
    if ((x != CH_ZERO && x != CH_ONE) || ch[31] || ch > 31) return {1'b0, m};
    m[ch[4:0]] = (x == CH_ONE);
    return {1'b1, m};
  endfunction

  function automatic void derive_counts();
    acnt_q = 0;
    for (int i = 0; i < 3; i++) acnt_q += amask_q[i];
    nib_q = (dmask_q[3:0] != 0) ? 4'd1 : 4'd0;
    if (dmask_q[7:4] != 0) nib_q += 1;
    if (dmask_q[15:8] != 0) nib_q += 2;
    if (dmask_q[31:16] != 0) nib_q += 4;
    if (nib_q == 1 && acnt_q > 0) nib_q = 2;
    dcnt_q = 0;
    for (int i = 0; i < 21; i++) dcnt_q += dmask_q[i];
    dbytes_q = 3'((dcnt_q + 6) / 7);
  endfunction

  function automatic line_outcome_e run_line();
    logic [31:0] v, pin;
    logic [32:0] upd;
    string       boot_word;
    boot_word = "bootsel";
    reply.delete();
    reply_byte(CH_STAR);
    case (line_at(0))
      CMD_BOOT: begin
        for (int k = 0; k < 7; k++) if (line_at(k) != boot_word[k]) return LINE_IGNORED;
        return (line_at(7) == 8'h00) ? LINE_BOOT : LINE_IGNORED;
      end
      CMD_ID: begin
        reply.delete();
        foreach (ID_HEAD[k]) reply_byte(ID_HEAD[k]);
        reply_text(",A");
        reply_dec(32'd3, 2);
        reply_text("1D");
        reply_dec(32'd21, 2);
        reply_text(",02");
        return LINE_REPLY;
      end
      CMD_RATE: begin
        v = decimal_at(1);
        if (v[31] || v < RATE_MIN || v > RATE_MAX) return LINE_IGNORED;
        rate_q = v;
        return LINE_REPLY;
      end
      CMD_LEN: begin
        v = decimal_at(1);
        if (v[31] || v == 0) return LINE_IGNORED;
        count_q = v;
        return LINE_REPLY;
      end
      CMD_ANA: begin
        v = decimal_at(1);
        if (!v[31]) begin
          reply.delete();
          reply_text("25700x0");
        end
        return LINE_REPLY;
      end
      CMD_FIXED, CMD_CONT: begin
        derive_counts();
        cont_q = (line_at(0) == CMD_CONT);
        return LINE_START;
      end
      CMD_T, CMD_P: return LINE_REPLY;
      CMD_AEN: begin
        upd = with_bit(amask_q);
        amask_q = upd[31:0];
        return upd[32] ? LINE_REPLY : LINE_IGNORED;
      end
      CMD_DEN: begin
        upd = with_bit(dmask_q);
        dmask_q = upd[31:0];
        return upd[32] ? LINE_REPLY : LINE_IGNORED;
      end
      CMD_NAME: begin
        v = decimal_at(2);
        reply.delete();
        if (line_at(1) == CMD_DEN) begin
          pin = v;
          if (pin_mode == 0) pin = v + 2;
          else if (pin_mode == 1 && !(v[31] || v <= PIN_SKIP_LIMIT)) pin = v + 3;
          reply_text("GP");
          reply_dec(pin, 1);
          return LINE_REPLY;
        end
        if (line_at(1) == CMD_AEN) begin
          reply_text("ADC");
          reply_dec(v, 1);
          reply_text("_GP");
          reply_dec(v + ADC_PIN_OFS, 1);
          return LINE_REPLY;
        end
        return LINE_IGNORED;
      end
      default: return LINE_IGNORED;
    endcase
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] b);
    result_t r;
    r = '{kind: kind, resp_byte: b, resp_last: 1'b0, continuous: cont_q,
          rate_hz: rate_q[26:0], sample_total: count_q[30:0],
          analog_mask: amask_q, digital_mask: dmask_q, analog_count: acnt_q,
          digital_count: dcnt_q, nibbles_per_slice: nib_q,
          digital_bytes_per_sample: dbytes_q};
    step_out.push_back(r);
  endfunction

  function automatic void accept_char(logic [7:0] c);
    line_outcome_e o;
    step_out.delete();
    if (c == CH_STAR) begin
      cont_q = 0;
      add_result(KIND_ABORT, 8'h00);
      n_abort++;
    end else if (c == CH_CR || c == CH_LF) begin
      o = run_line();
      line_len = 0;
      case (o)
        LINE_REPLY: begin
          foreach (reply[k]) add_result(KIND_RESP, reply[k]);
          n_reply++;
        end
        LINE_START: begin
          add_result(KIND_START, 8'h00);
          n_start++;
        end
        LINE_BOOT: begin
          add_result(KIND_BOOT, 8'h00);
          n_boot++;
        end
        default: ;
      endcase
    end else begin
      if (line_len >= LINE_MAX) line_len = 0;
      line_mem[line_len] = c;
      line_len++;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].resp_last = 1'b1;
    foreach (step_out[k]) expected_results.push_back(step_out[k]);
  endfunction

  task automatic report_fault(string msg, result_t e, result_t g);
    errors++;
    if (errors <= 10) $display("%0d: %s expected %h actual %h", cycles, msg, e, g);
  endtask

  // sampling, prediction and checking
  always @(posedge clk_i) begin
    result_t got;
    cycles++;
    if (rst_ni && cmd_ch.valid && cmd_ch.ready) begin
      accept_char(cmd_ch.char_in);
      cmd_taken = 1;
      chars_done++;
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{kind: res_ch.kind, resp_byte: res_ch.resp_byte, resp_last: res_ch.resp_last,
              continuous: res_ch.continuous, rate_hz: res_ch.rate_hz,
              sample_total: res_ch.sample_total, analog_mask: res_ch.analog_mask,
              digital_mask: res_ch.digital_mask, analog_count: res_ch.analog_count,
              digital_count: res_ch.digital_count,
              nibbles_per_slice: res_ch.nibbles_per_slice,
              digital_bytes_per_sample: res_ch.digital_bytes_per_sample};
      results_seen++;
      if (expected_results.size() == 0) report_fault("unexpected request", '0, got);
      else if (got !== expected_results[0]) begin
        report_fault("request mismatch", expected_results[0], got);
        void'(expected_results.pop_front());
      end else void'(expected_results.pop_front());
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // character driver and result stall
  always @(negedge clk_i) begin
    logic       nv;
    logic [7:0] nc;
    nv = cmd_ch.valid;
    nc = cmd_ch.char_in;
    if (!rst_ni) nv = 0;
    else if (!cmd_ch.valid || cmd_taken) begin
      cmd_taken = 0;
      if (char_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        nv = 1;
        nc = char_queue.pop_front();
      end else nv = 0;
    end
    cmd_ch.valid <= nv;
    cmd_ch.char_in <= nc;
    res_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall);
  end

  task automatic send_byte(logic [7:0] c);
    char_queue.push_back(c);
    chars_queued++;
  endtask

  task automatic send_line(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    send_byte($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  function automatic string num_text();
    case ($urandom_range(8))
      0, 1: return $sformatf("%0d", $urandom_range(40));
      2: case ($urandom_range(3))
           0: return "4999";
           1: return "5000";
           2: return "120000016";
           default: return "120000017";
         endcase
      3: return $sformatf("%0d", $urandom_range(5000, 200000));
      4: case ($urandom_range(3))
           0: return "99999999999";
           1: return "2147483648";
           2: return "-2147483649";
           default: return "2147483647";
         endcase
      5: return $sformatf("-%0d", $urandom_range(30));
      6: return $sformatf(" +%0d", $urandom_range(9999));
      7: return $sformatf("\t%0d", $urandom_range(99));
      default: return "";
    endcase
  endfunction

  function automatic string chan_text();
    return $urandom_range(3) ? $sformatf("%0d", $urandom_range(33)) : num_text();
  endfunction

  function automatic string bit_text();
    case ($urandom_range(4))
      0, 1: return "0";
      2, 3: return "1";
      default: return "x";
    endcase
  endfunction

  task automatic rand_line();
    int n;
    case ($urandom_range(15))
      0: send_line("i");
      1: send_line({"R", num_text()});
      2: send_line({"L", num_text()});
      3: send_line({"a", num_text()});
      4: send_line($urandom_range(1) ? "t" : "p");
      5: send_line({"A", bit_text(), chan_text()});
      6: send_line({"D", bit_text(), chan_text()});
      7: send_line({"nD", num_text()});
      8: send_line({"nA", num_text()});
      9: send_line($urandom_range(1) ? "F" : "C");
      10: send_line($urandom_range(2) ? "bootsel" : "bootse");
      11: begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
      12: begin
        n = LINE_MAX + $urandom_range(3);
        repeat (n) send_byte(8'($urandom_range(8'h61, 8'h7A)));
        send_line($urandom_range(1) ? "i" : {"D1", chan_text()});
      end
      13: begin
        send_byte(CMD_RATE);
        send_byte(CH_STAR);
        send_line(num_text());
      end
      14: send_line({"Q", num_text()});
      default: send_line("");
    endcase
  endtask

  task automatic directed_lines();
    send_line("i");
    send_line("R4999");
    send_line("R5000");
    send_line("R120000016");
    send_line("R120000017");
    send_line("L0");
    send_line("L99999999999");
    send_line("a-1");
    send_line("a5");
    send_line("t");
    send_line("p");
    send_line("A01");
    send_line("A12");
    send_line("D131");
    send_line("D032");
    send_line("nD-3");
    send_line("nA2147483647");
    send_line("F");
    send_line("C");
    send_byte(CH_STAR);
    send_line("bootsel");
    send_line("xxxxxxxxxxxxxxxxxxxi");
    send_line("");
    send_byte(8'hFF);
    send_line("");
  endtask

  task automatic write_pin_map(logic [1:0] mode);
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_PIN_MAP;
    pwdata <= 32'(mode);
    penable <= 0;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    pin_mode = mode;
  endtask

  task automatic wait_idle();
    while (char_queue.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  initial begin
    int          idle_pct [4];
    int          stall_pct [4];
    logic [1:0]  modes [4];
    int          n;
    idle_pct = '{0, 45, 0, 26};
    stall_pct = '{0, 0, 45, 26};
    modes = '{2'd0, 2'd1, 2'd2, 2'd3};
    clk_i = 0;
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 0;
    cmd_ch.char_in = '0;
    res_ch.ready = 0;
    line_len = 0;
    rate_q = RATE_MIN;
    count_q = 32'd10;
    amask_q = 0;
    dmask_q = 0;
    cont_q = 0;
    acnt_q = 0;
    dcnt_q = 0;
    nib_q = 0;
    dbytes_q = 0;
    pin_mode = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    for (int ph = 0; ph < 4; ph++) begin
      write_pin_map(modes[ph]);
      send_idle = idle_pct[ph];
      recv_stall = stall_pct[ph];
      if (ph == 0) directed_lines();
      n = chars_queued + PHASE_CHARS;
      while (chars_queued < n) rand_line();
      wait_idle();
    end
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0d requests never arrived", expected_results.size());
    end
    $display("%0d characters, %0d result requests: %0d replies, %0d starts, %0d bootsel,",
             chars_done, results_seen, n_reply, n_start, n_boot);
    $display("%0d aborts over pin map modes 0 to 3; %0d errors", n_abort, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cclp_pkg.sv
rtl/cclp_if.sv
rtl/cclp_bcd.sv
rtl/capture_command_line_parser.sv
rtl/cclp_checker.sv
test/tb_capture_command_line_parser.sv
